// ===== rtl/nmea_pkg.sv =====
// Package for the NMEA 0183 sentence parser core.
// Holds character codes, sentence type codes, status codes, limits and the hex decoder.
// Used by nmea_sentence_parser_core; depends on nothing else.
package nmea_pkg;

	localparam int MaxSentence = 127;
	localparam int MaxFields   = 31;

	// The counters are 7 and 5 bits wide, so the limits clip there.
	localparam logic [6:0] LEN_LIMIT = 7'((MaxSentence < 127) ? MaxSentence : 127);
	localparam logic [4:0] FIELD_CAP = 5'((MaxFields < 31) ? MaxFields : 31);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam int NumTypes = 6;
	localparam logic [39:0] TYPE_CODES [NumTypes] = '{
		40'h4750474741, // GPGGA
		40'h4750524D43, // GPRMC
		40'h4750565447, // GPVTG
		40'h4750524D42, // GPRMB
		40'h4750475341, // GPGSA
		40'h4750475356  // GPGSV
	};

	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CHECKSUM  = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_BAD_HEX   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic KIND_FIELD    = 1'b0;
	localparam logic KIND_SENTENCE = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_BODY = 4'b0010,
		PH_HEX1 = 4'b0100,
		PH_HEX2 = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} hex_t;

	// Decodes one checksum digit; anything that is not a hex digit is bad and reads as zero.
	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t       h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d = b - 8'h30;
			h.value = d[3:0];
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d = b - 8'h37;
			h.value = d[3:0];
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d = b - 8'h57;
			h.value = d[3:0];
		end else begin
			h.bad = 1'b1;
		end
		return h;
	endfunction

endpackage

// ===== rtl/nmea_sentence_parser_core.sv =====
// Top level of the NMEA 0183 sentence parser: byte stream in, field and sentence items out.
// Depends on nmea_pkg for codes, limits and the hex decoder.
//
// Channel   Dir  Signals                      Content
// s_        in   tvalid tready tdata[7:0]     in_byte
// m_        out  tvalid tready tdata[39:0]    field and sentence results
//                tuser                        result_kind
//
// One byte is accepted every cycle while the output side takes results.
// A byte goes through the input register, then one pass of parse logic updates the
// sentence state and loads the result register. A waiting result stalls the parse
// stage; one more byte is still taken into the input register. Reset clears the parse
// state to idle, waiting for a dollar sign.
module nmea_sentence_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] field_index, [11:5] field_start, [18:12] field_length, [21:19] status,
	// [24:22] sentence_type, [32:25] checksum_calc, [37:33] field_total, [39:38] zero
	output logic [39:0] m_tdata,
	output logic        m_tuser   // [0] result_kind
);
	import nmea_pkg::*;

	logic        s1_valid_q;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [3:0]  nibble_q, nibble_d;
	logic [39:0] addr_q, addr_d;
	logic [6:0]  count_q, count_d;
	logic [4:0]  field_q, field_d;
	logic [6:0]  start_q, start_d;
	logic        ovf_q, ovf_d;
	logic        bad_q, bad_d;

	logic        res_valid;
	logic        res_kind;
	logic [4:0]  res_index;
	logic [6:0]  res_start;
	logic [6:0]  res_length;
	logic [2:0]  res_status;
	logic [2:0]  res_type;
	logic [7:0]  res_xor;
	logic [4:0]  res_total;

	logic        out_free;
	logic        s1_fire;
	logic        close_ok;
	logic [6:0]  close_len;
	hex_t        hex;
	logic [7:0]  sum;
	logic [2:0]  match_type;

	assign out_free = !m_tvalid || m_tready;
	assign s1_fire  = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// A field closes at the current offset only when it holds at least one character.
	assign close_ok  = !ovf_q && (field_q != 5'd0) && (count_q > start_q);
	assign close_len = count_q - start_q;
	assign hex       = hex_decode(byte_s1);
	assign sum       = {nibble_q, hex.value};

	always_comb begin
		match_type = TYPE_UNKNOWN;
		if (count_q >= 7'd5) begin
			for (int i = NumTypes - 1; i >= 0; i--) begin
				if (addr_q == TYPE_CODES[i]) begin
					match_type = 3'(i + 1);
				end
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		nibble_d = nibble_q;
		addr_d   = addr_q;
		count_d  = count_q;
		field_d  = field_q;
		start_d  = start_q;
		ovf_d    = ovf_q;
		bad_d    = bad_q;

		res_valid  = 1'b0;
		res_kind   = KIND_FIELD;
		res_index  = '0;
		res_start  = '0;
		res_length = '0;
		res_status = ST_OK;
		res_type   = TYPE_UNKNOWN;
		res_xor    = '0;
		res_total  = '0;

		if (byte_s1 == CH_DOLLAR) begin
			phase_d  = PH_BODY;
			xor_d    = '0;
			nibble_d = '0;
			addr_d   = '0;
			count_d  = '0;
			field_d  = '0;
			start_d  = '0;
			ovf_d    = 1'b0;
			bad_d    = 1'b0;
		end else begin
			unique case (phase_q)
				PH_BODY: begin
					if (byte_s1 == CH_STAR) begin
						res_valid  = close_ok;
						res_index  = field_q;
						res_start  = start_q;
						res_length = close_len;
						phase_d    = PH_HEX1;
					end else begin
						xor_d = xor_q ^ byte_s1;
						if (ovf_q || count_q >= LEN_LIMIT) begin
							// Past the length limit the byte still counts toward the checksum only.
							ovf_d = 1'b1;
						end else begin
							if (count_q < 7'd5) begin
								addr_d = {addr_q[31:0], byte_s1};
							end
							if (byte_s1 == CH_COMMA) begin
								res_valid  = close_ok;
								res_index  = field_q;
								res_start  = start_q;
								res_length = close_len;
								if (field_q < FIELD_CAP) begin
									field_d = field_q + 5'd1;
								end
								start_d = count_q + 7'd1;
							end
							count_d = count_q + 7'd1;
						end
					end
				end
				PH_HEX1: begin
					nibble_d = hex.value;
					bad_d    = bad_q | hex.bad;
					phase_d  = PH_HEX2;
				end
				PH_HEX2: begin
					bad_d     = bad_q | hex.bad;
					res_valid = 1'b1;
					res_kind  = KIND_SENTENCE;
					res_type  = match_type;
					res_xor   = xor_q;
					res_total = field_q;
					priority if (ovf_q) begin
						res_status = ST_TOO_LONG;
					end else if (bad_q || hex.bad) begin
						res_status = ST_BAD_HEX;
					end else if (sum != xor_q) begin
						res_status = ST_CHECKSUM;
					end else if (match_type == TYPE_UNKNOWN) begin
						res_status = ST_UNKNOWN;
					end else begin
						res_status = ST_OK;
					end
					phase_d = PH_IDLE;
				end
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xor_q    <= '0;
			nibble_q <= '0;
			addr_q   <= '0;
			count_q  <= '0;
			field_q  <= '0;
			start_q  <= '0;
			ovf_q    <= 1'b0;
			bad_q    <= 1'b0;
		end else if (s1_fire) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			nibble_q <= nibble_d;
			addr_q   <= addr_d;
			count_q  <= count_d;
			field_q  <= field_d;
			start_q  <= start_d;
			ovf_q    <= ovf_d;
			bad_q    <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= s1_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			m_tuser <= res_kind;
			m_tdata <= {2'b00, res_total, res_xor, res_type, res_status,
			            res_length, res_start, res_index};
		end
	end

`ifndef SYNTHESIS
	// Once the body runs over, the character count sits at the length limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == LEN_LIMIT))
		else $error("overflow set with count away from the limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FIELD_CAP)
		else $error("field counter beyond its cap");

	// A held result with a held byte behind it must stop the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while parse stage is blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_FIELD)) |-> (m_tdata[18:12] != 7'd0))
		else $error("field item with zero length");

	// A sentence item can only come from the second checksum digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && res_valid && (res_kind == KIND_SENTENCE)) |-> (phase_q == PH_HEX2))
		else $error("sentence item outside the checksum phase");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nmea_sentence_parser_core: drives NMEA byte streams into the
// slave side and checks each field and sentence item against a cycle-free predictor.
// Depends on nmea_pkg and nmea_sentence_parser_core.
module testbench;
	import nmea_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [4:0] idx;
		logic [6:0] start;
		logic [6:0] len;
		logic [2:0] status;
		logic [2:0] stype;
		logic [7:0] csum;
		logic [4:0] total;
	} parse_result_t;

	typedef enum int { SHAPE_NORMAL, SHAPE_LONG, SHAPE_WIDE } shape_t;
	typedef enum int { END_UPPER, END_LOWER, END_WRONG, END_BADHEX } ending_t;

	localparam int TARGET_ITEMS = 1250;

	// Tracks the parser state from accepted bytes and holds the items it must produce.
	class sentence_tracker;
		phase_t        phase;
		logic [7:0]    xsum;
		logic [3:0]    high_digit;
		logic [39:0]   addr;
		int            count;
		logic [4:0]    fld;
		int            fstart;
		bit            ovf;
		bit            badhex;
		parse_result_t pending_results[$];
		int            errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_IDLE;
			xsum = '0;
			high_digit = '0;
			addr = '0;
			count = 0;
			fld = '0;
			fstart = 0;
			ovf = 0;
			badhex = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function logic [3:0] digit_value(logic [7:0] b);
			if (b >= "0" && b <= "9") return 4'(b - "0");
			if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
			if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
			badhex = 1;
			return 4'd0;
		endfunction

		function bit close_field(output parse_result_t r);
			int len;
			r = '0;
			if (ovf || fld == 0 || count < fstart) return 0;
			len = count - fstart;
			if (len == 0) return 0;
			r.kind = KIND_FIELD;
			r.idx = fld;
			r.start = 7'(fstart);
			r.len = 7'(len);
			return 1;
		endfunction

		// Returns 1 when the byte mattered to the parser, 0 when it was ignored while idle.
		function bit take_byte(logic [7:0] b);
			parse_result_t r;
			bit            got;
			logic [3:0]    lo;
			logic [7:0]    sum;
			logic [2:0]    stype;
			r = '0;
			got = 0;
			if (b == CH_DOLLAR) begin
				clear();
				phase = PH_BODY;
				return 1;
			end
			case (phase)
				PH_IDLE: return 0;
				PH_BODY: begin
					if (b == CH_STAR) begin
						got = close_field(r);
						phase = PH_HEX1;
					end else begin
						xsum ^= b;
						if (ovf || count >= int'(LEN_LIMIT)) begin
							ovf = 1;
						end else begin
							if (count < 5) addr = {addr[31:0], b};
							if (b == CH_COMMA) begin
								got = close_field(r);
								if (fld < FIELD_CAP) fld++;
								fstart = count + 1;
							end
							count++;
						end
					end
				end
				PH_HEX1: begin
					high_digit = digit_value(b);
					phase = PH_HEX2;
				end
				PH_HEX2: begin
					lo = digit_value(b);
					sum = {high_digit, lo};
					stype = TYPE_UNKNOWN;
					if (count >= 5) begin
						for (int i = 0; i < NumTypes; i++) begin
							if (addr == TYPE_CODES[i]) begin
								stype = 3'(i + 1);
								break;
							end
						end
					end
					r.kind = KIND_SENTENCE;
					if (ovf) r.status = ST_TOO_LONG;
					else if (badhex) r.status = ST_BAD_HEX;
					else if (sum != xsum) r.status = ST_CHECKSUM;
					else if (stype == TYPE_UNKNOWN) r.status = ST_UNKNOWN;
					else r.status = ST_OK;
					r.stype = stype;
					r.csum = xsum;
					r.total = fld;
					got = 1;
					phase = PH_IDLE;
				end
				default: ;
			endcase
			if (got) pending_results.push_back(r);
			return 1;
		endfunction

		function void match_result(logic [39:0] data, logic user);
			parse_result_t e;
			parse_result_t a;
			a.kind = user;
			a.idx = data[4:0];
			a.start = data[11:5];
			a.len = data[18:12];
			a.status = data[21:19];
			a.stype = data[24:22];
			a.csum = data[32:25];
			a.total = data[37:33];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected item kind=%0d tdata=%h", $realtime, user, data);
				return;
			end
			e = pending_results.pop_front();
			if (a !== e || data[39:38] !== 2'b00) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: expected kind=%0d idx=%0d start=%0d len=%0d",
						$realtime, e.kind, e.idx, e.start, e.len);
					$display("%0t:          st=%0d ty=%0d cs=%h tot=%0d",
						$realtime, e.status, e.stype, e.csum, e.total);
					$display("%0t: actual   kind=%0d idx=%0d start=%0d len=%0d",
						$realtime, a.kind, a.idx, a.start, a.len);
					$display("%0t:          st=%0d ty=%0d cs=%h tot=%0d pad=%b",
						$realtime, a.status, a.stype, a.csum, a.total, data[39:38]);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	sentence_tracker sb;
	logic [7:0]      line_q[$];
	bit              steady = 0;
	int              taken_items = 0;
	int              stall_left = 0;

	nmea_sentence_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (sb.take_byte(s_tdata)) taken_items++;
		end
		if (arst_n && m_tvalid && m_tready) sb.match_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 25) begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_byte(line_q[i]);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
	endtask

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 9) < 7) c = 8'($urandom_range(8'h20, 8'h7E));
			else c = 8'($urandom_range(0, 255));
		end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 10) return 8'("0" + n);
		return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_DOLLAR || (c >= "0" && c <= "9") || (c >= "A" && c <= "F")
			|| (c >= "a" && c <= "f"));
		return c;
	endfunction

	// Appends the asterisk and two checksum digits over everything after the dollar sign.
	function automatic void close_line(ending_t how);
		logic [7:0] xs;
		logic [7:0] sum;
		xs = '0;
		for (int i = 1; i < line_q.size(); i++) xs ^= line_q[i];
		sum = (how == END_WRONG) ? xs ^ 8'($urandom_range(1, 255)) : xs;
		line_q.push_back(CH_STAR);
		line_q.push_back(hex_char(sum[7:4], how == END_LOWER));
		line_q.push_back(hex_char(sum[3:0], how == END_LOWER));
		if (how == END_BADHEX) line_q[line_q.size() - 1 - $urandom_range(0, 1)] = non_hex_char();
	endfunction

	function automatic void build_sentence(shape_t shape);
		logic [39:0] code;
		int          r;
		int          nfields;
		int          len;
		ending_t     how;
		line_q.delete();
		line_q.push_back(CH_DOLLAR);
		code = TYPE_CODES[$urandom_range(0, NumTypes - 1)];
		r = $urandom_range(0, 99);
		if (r < 75) begin
			for (int k = 0; k < 5; k++) line_q.push_back(code[39 - 8 * k -: 8]);
		end else if (r < 85) begin
			for (int k = 0; k < 5; k++) line_q.push_back(body_char());
		end else if (r < 93) begin
			// Near miss: one bit off in the last address character.
			for (int k = 0; k < 4; k++) line_q.push_back(code[39 - 8 * k -: 8]);
			line_q.push_back(code[7:0] ^ (8'h01 << $urandom_range(0, 6)));
		end else begin
			len = $urandom_range(0, 4);
			for (int k = 0; k < len; k++) line_q.push_back(body_char());
		end
		nfields = (shape == SHAPE_WIDE) ? $urandom_range(32, 40) : $urandom_range(0, 12);
		for (int f = 0; f < nfields; f++) begin
			line_q.push_back(CH_COMMA);
			if (shape == SHAPE_WIDE) len = $urandom_range(0, 2);
			else len = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 7);
			for (int k = 0; k < len; k++) line_q.push_back(body_char());
		end
		if (shape == SHAPE_LONG) begin
			len = $urandom_range(124, 150);
			while (line_q.size() - 1 < len)
				line_q.push_back(($urandom_range(0, 9) == 0) ? CH_COMMA : body_char());
		end
		r = $urandom_range(0, 99);
		if (r < 78) how = END_UPPER;
		else if (r < 88) how = END_LOWER;
		else if (r < 94) how = END_WRONG;
		else how = END_BADHEX;
		close_line(how);
	endfunction

	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int     r;
		int     n;
		int     sentences;
		shape_t shape;
		string  head;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle noise, a dropped start, a clean sentence with empty fields and lowercase digits.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("$GP");
		line_q = {CH_DOLLAR};
		head = "GPGSV,a,,bc";
		for (int i = 0; i < head.len(); i++) line_q.push_back(8'(head[i]));
		close_line(END_LOWER);
		send_line();
		// Short address with a bad digit, then a wrong checksum on a known type.
		send_text("$AB*G5");
		send_text("$GPRMC,x*00");

		sentences = 0;
		while (taken_items < TARGET_ITEMS) begin
			steady = ($urandom_range(0, 99) < 15);
			if (sentences == 8) begin
				s_tvalid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) begin
					line_q = {8'($urandom_range(0, 255))};
					if (line_q[0] == CH_DOLLAR) line_q[0] = 8'h25;
					send_line();
				end
			end else begin
				if (r < 20) shape = SHAPE_LONG;
				else if (r < 24) shape = SHAPE_WIDE;
				else shape = SHAPE_NORMAL;
				build_sentence(shape);
				// Broken sentences are cut short; the next dollar sign drops them.
				if (r >= 90) begin
					n = $urandom_range(1, line_q.size() - 1);
					while (line_q.size() > n) void'(line_q.pop_back());
				end
				send_line();
				sentences++;
			end
		end
		s_tvalid <= 1'b0;
		steady = 0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/nmea_pkg.sv
rtl/nmea_sentence_parser_core.sv
bench/testbench.sv
